FILE: sv/tbmc_pkg.sv
// ----------------------------------------------------------------------------
// Two-button controller package
// Key and mode codes, date positions, register indexes and the packed
// result layout shared by the controller core.
// ----------------------------------------------------------------------------
package tbmc_pkg;

   typedef enum logic [1:0] {
      KEY_NONE   = 2'd0,
      KEY_START  = 2'd1,
      KEY_MEMORY = 2'd2,
      KEY_COMBO  = 2'd3
   } key_type;

   typedef enum logic [1:0] {
      MODE_STANDBY = 2'd0,
      MODE_DATESET = 2'd1,
      MODE_MEASURE = 2'd2,
      MODE_MEMORY  = 2'd3
   } mode_type;

   localparam logic [2:0] POS_MONTH  = 3'd1;
   localparam logic [2:0] POS_DAY    = 3'd2;
   localparam logic [2:0] POS_HOUR   = 3'd3;
   localparam logic [2:0] POS_MINUTE = 3'd4;

   localparam logic REG_YEAR = 1'b0;
   localparam logic REG_HOLD = 1'b1;

   localparam logic [6:0] YEAR_RESET = 7'd13;
   localparam logic [3:0] HOLD_RESET = 4'd4;
   localparam logic [3:0] HOLD_MAX   = 4'd15;

   localparam logic [3:0] MONTH_LAST  = 4'd12;
   localparam logic [5:0] DAY_LONG    = 6'd31;
   localparam logic [5:0] DAY_SHORT   = 6'd30;
   localparam logic [5:0] DAY_FEB     = 6'd28;
   localparam logic [5:0] DAY_FEB_LEAP = 6'd29;
   localparam logic [4:0] HOURS       = 5'd24;
   localparam logic [5:0] MINUTES     = 6'd60;

   localparam int REQ_W = 16;
   localparam int RSP_W = 40;
   localparam int CSR_W = 7;

   typedef struct packed {
      logic          spare;
      logic          record_refresh;
      logic          record_close;
      logic          measure_stop;
      logic          clock_load;
      key_type       key_event;
      logic [7:0]    record_index;
      logic [5:0]    minute_value;
      logic [4:0]    hour_value;
      logic [4:0]    day_value;
      logic [3:0]    month_value;
      logic [2:0]    set_position;
      mode_type      mode;
   } rsp_type;

endpackage

FILE: sv/two_button_mode_and_clock_set_controller_core.sv
// ----------------------------------------------------------------------------
// Two-button mode and clock-set controller
// Debounces two active-low buttons into start, memory and combination keys,
// and steps a four-mode machine with date editing and record browsing.
//
// Channel  Direction  Content
// req      in         one button scan per request
// rsp      out        one result per request
// csr      in         register writes: year in century, hold ticks
//
// Each request is worked out in the cycle it is accepted and its result is
// registered; one request can be taken in every cycle. A skid register holds
// a second result while the output is stalled, and requests are refused only
// while it is full. Reset is synchronous and restores the registers and state.
// ----------------------------------------------------------------------------
module two_button_mode_and_clock_set_controller_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // start_pin, memory_pin, record_total[7:0], zero padding
   input  logic [tbmc_pkg::REQ_W-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // mode[1:0], set_position[2:0], month_value[3:0], day_value[4:0],
   // hour_value[4:0], minute_value[5:0], record_index[7:0], key_event[1:0],
   // clock_load, measure_stop, record_close, record_refresh, zero padding
   output logic [tbmc_pkg::RSP_W-1:0] rsp_tdata,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic                       csr_index,
   input  logic [tbmc_pkg::CSR_W-1:0] csr_data
);
   import tbmc_pkg::*;

   logic [6:0] year_ff;
   logic [3:0] hold_ticks_ff;

   logic [3:0] hold_count_ff, hold_count_in;
   key_type    last_key_ff, last_key_in;
   key_type    pending_ff, pending_in;
   mode_type   mode_ff, mode_in;
   logic [2:0] position_ff, position_in;
   logic [3:0] month_ff, month_in;
   logic [4:0] day_ff, day_in;
   logic [4:0] hour_ff, hour_in;
   logic [5:0] minute_ff, minute_in;
   logic [7:0] index_ff, index_in;

   rsp_type    out_ff, skid_ff, result;
   logic       out_valid_ff, skid_valid_ff;

   logic       start_down, memory_down, released;
   logic [7:0] total;
   key_type    scan, fired;
   logic       accept, pop;
   logic       clock_load, measure_stop, record_close, record_refresh;
   logic       short_month, leap;
   logic [3:0] month_step;
   logic [5:0] day_step;
   logic [4:0] hour_step;
   logic [5:0] minute_step;
   logic [8:0] index_step;
   logic       index_done;

   assign start_down  = ~req_tdata[0];
   assign memory_down = ~req_tdata[1];
   assign total       = req_tdata[9:2];
   assign released    = ~start_down & ~memory_down;

   assign accept     = req_tvalid & req_tready;
   assign pop        = rsp_tvalid & rsp_tready;
   assign req_tready = ~skid_valid_ff;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff;
   assign csr_ready  = 1'b1;

   always_comb begin
      if (start_down && memory_down) begin
         scan = KEY_COMBO;
      end else if (start_down) begin
         scan = KEY_START;
      end else if (memory_down) begin
         scan = KEY_MEMORY;
      end else begin
         scan = KEY_NONE;
      end
   end

   always_comb begin
      hold_count_in = hold_count_ff;
      last_key_in   = last_key_ff;
      pending_in    = pending_ff;
      fired         = KEY_NONE;
      if (released) begin
         last_key_in = KEY_NONE;
         fired       = pending_ff;
         pending_in  = KEY_NONE;
      end else begin
         if (last_key_ff == scan) begin
            if (hold_count_ff < HOLD_MAX) begin
               hold_count_in = hold_count_ff + 4'd1;
            end
         end else begin
            last_key_in   = scan;
            hold_count_in = 4'd0;
         end
         if (hold_count_in >= hold_ticks_ff) begin
            pending_in = scan;
         end
      end
   end

   assign month_step  = month_ff + 4'd1;
   assign day_step    = {1'b0, day_ff} + 6'd1;
   assign hour_step   = hour_ff + 5'd1;
   assign minute_step = minute_ff + 6'd1;
   assign index_step  = {1'b0, index_ff} + 9'd1;
   assign index_done  = index_step >= {1'b0, total};
   assign short_month = (month_ff == 4'd4) || (month_ff == 4'd6) ||
                        (month_ff == 4'd9) || (month_ff == 4'd11);
   assign leap        = year_ff[1:0] == 2'b00;

   // Next mode.
   always_comb begin
      mode_in = mode_ff;
      if (fired != KEY_NONE) begin
         unique case (mode_ff)
            MODE_STANDBY: begin
               if (fired == KEY_COMBO) begin
                  mode_in = MODE_DATESET;
               end else if (fired == KEY_START) begin
                  mode_in = MODE_MEASURE;
               end else begin
                  mode_in = MODE_MEMORY;
               end
            end
            MODE_DATESET: begin
               if (fired == KEY_START && position_ff >= POS_MINUTE) begin
                  mode_in = MODE_STANDBY;
               end
            end
            MODE_MEASURE: begin
               if (fired != KEY_MEMORY) begin
                  mode_in = MODE_STANDBY;
               end
            end
            MODE_MEMORY: begin
               if (fired != KEY_MEMORY || index_done) begin
                  mode_in = MODE_STANDBY;
               end
            end
            default: mode_in = MODE_STANDBY;
         endcase
      end
   end

   // Field updates and pulses.
   always_comb begin
      position_in    = position_ff;
      month_in       = month_ff;
      day_in         = day_ff;
      hour_in        = hour_ff;
      minute_in      = minute_ff;
      index_in       = index_ff;
      clock_load     = 1'b0;
      measure_stop   = 1'b0;
      record_close   = 1'b0;
      record_refresh = 1'b0;
      if (fired != KEY_NONE) begin
         unique case (mode_ff)
            MODE_STANDBY: begin
            end
            MODE_DATESET: begin
               if (fired == KEY_START) begin
                  if (position_ff >= POS_MINUTE) begin
                     position_in = POS_MONTH;
                     clock_load  = 1'b1;
                  end else begin
                     position_in = position_ff + 3'd1;
                  end
               end else begin
                  unique case (position_ff)
                     POS_MONTH: begin
                        month_in = (month_step > MONTH_LAST) ? 4'd1 : month_step;
                     end
                     POS_DAY: begin
                        if (day_step > DAY_SHORT && short_month) begin
                           day_in = 5'd1;
                        end else if (day_step > DAY_LONG) begin
                           day_in = 5'd1;
                        end else if (month_ff == 4'd2 &&
                                     day_step > (leap ? DAY_FEB_LEAP : DAY_FEB)) begin
                           day_in = 5'd1;
                        end else begin
                           day_in = day_step[4:0];
                        end
                     end
                     POS_HOUR: begin
                        hour_in = (hour_step >= HOURS) ? 5'd0 : hour_step;
                     end
                     POS_MINUTE: begin
                        minute_in = (minute_step >= MINUTES) ? 6'd0 : minute_step;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            MODE_MEASURE: begin
               if (fired != KEY_MEMORY) begin
                  measure_stop = 1'b1;
                  record_close = 1'b1;
               end
            end
            MODE_MEMORY: begin
               if (fired != KEY_MEMORY || index_done) begin
                  index_in     = 8'd0;
                  record_close = 1'b1;
               end else begin
                  index_in       = index_step[7:0];
                  record_refresh = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      result.spare          = 1'b0;
      result.record_refresh = record_refresh;
      result.record_close   = record_close;
      result.measure_stop   = measure_stop;
      result.clock_load     = clock_load;
      result.key_event      = fired;
      result.record_index   = index_in;
      result.minute_value   = minute_in;
      result.hour_value     = hour_in;
      result.day_value      = day_in;
      result.month_value    = month_in;
      result.set_position   = position_in;
      result.mode           = mode_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         year_ff       <= YEAR_RESET;
         hold_ticks_ff <= HOLD_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_YEAR: year_ff       <= csr_data;
            REG_HOLD: hold_ticks_ff <= csr_data[3:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_count_ff <= 4'd0;
         last_key_ff   <= KEY_NONE;
         pending_ff    <= KEY_NONE;
         mode_ff       <= MODE_STANDBY;
         position_ff   <= POS_MONTH;
         month_ff      <= 4'd1;
         day_ff        <= 5'd1;
         hour_ff       <= 5'd0;
         minute_ff     <= 6'd0;
         index_ff      <= 8'd0;
      end else if (accept) begin
         hold_count_ff <= hold_count_in;
         last_key_ff   <= last_key_in;
         pending_ff    <= pending_in;
         mode_ff       <= mode_in;
         position_ff   <= position_in;
         month_ff      <= month_in;
         day_ff        <= day_in;
         hour_ff       <= hour_in;
         minute_ff     <= minute_in;
         index_ff      <= index_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (skid_valid_ff && pop) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else if (accept) begin
            if (!out_valid_ff || pop) begin
               out_valid_ff <= 1'b1;
            end else begin
               skid_valid_ff <= 1'b1;
            end
         end else if (pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff && pop) begin
         out_ff <= skid_ff;
      end else if (accept) begin
         if (!out_valid_ff || pop) begin
            out_ff <= result;
         end else begin
            skid_ff <= result;
         end
      end
   end

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// Testbench for the two-button mode and clock-set controller
// Button scans are sent as requests with random gaps while results are taken
// with random stalls. A model of the debouncer and mode machine in the
// testbench works out each result, which is compared field by field with what
// the block returns. The run goes through several year and hold settings.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import tbmc_pkg::*;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b1;
   logic [RSP_W-1:0] rsp_tdata;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic             csr_index = REG_YEAR;
   logic [CSR_W-1:0] csr_data = '0;

   two_button_mode_and_clock_set_controller_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Controller model state and settings
   logic [6:0] year_cfg = YEAR_RESET;
   logic [3:0] hold_cfg = HOLD_RESET;
   logic [3:0] hold_count = '0;
   key_type    last_key = KEY_NONE;
   key_type    pending_key = KEY_NONE;
   mode_type   ctrl_mode = MODE_STANDBY;
   logic [2:0] edit_position = POS_MONTH;
   logic [3:0] edit_month = 4'd1;
   logic [4:0] edit_day = 5'd1;
   logic [4:0] edit_hour = '0;
   logic [5:0] edit_minute = '0;
   logic [7:0] browse_index = '0;

   logic [REQ_W-1:0] scan_queue [$];
   rsp_type          status_due [$];
   int unsigned      queued_scans = 0;
   int unsigned      mismatches = 0;
   int unsigned      req_gap = 0;
   int unsigned      rsp_stall = 0;
   bit               calm = 1'b0;
   logic             req_taken = 1'b0;
   logic             rsp_taken = 1'b0;

   int unsigned phase_year [4] = '{0, 99, 28, 60};
   int unsigned phase_hold [4] = '{0, 15, 1, 2};
   int unsigned phase_start [4] = '{5, 30, 5, 20};

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("Some tests failed");
      $finish;
   end

   function automatic void debounce_scan(key_type k);
      if (last_key == k) begin
         if (hold_count < HOLD_MAX) hold_count = hold_count + 4'd1;
      end else begin
         last_key = k;
         hold_count = '0;
      end
      if (hold_count >= hold_cfg) pending_key = k;
   endfunction

   function automatic void step_edited_field();
      logic [5:0] day_next;
      logic [5:0] feb_limit;
      logic       short_month;
      case (edit_position)
         POS_MONTH: begin
            edit_month = (edit_month >= MONTH_LAST) ? 4'd1 : edit_month + 4'd1;
         end
         POS_DAY: begin
            short_month = (edit_month == 4'd4) || (edit_month == 4'd6) ||
                          (edit_month == 4'd9) || (edit_month == 4'd11);
            feb_limit = (year_cfg[1:0] != 2'd0) ? DAY_FEB : DAY_FEB_LEAP;
            day_next = {1'b0, edit_day} + 6'd1;
            if ((short_month && day_next > DAY_SHORT) || day_next > DAY_LONG ||
                (edit_month == 4'd2 && day_next > feb_limit)) day_next = 6'd1;
            edit_day = day_next[4:0];
         end
         POS_HOUR: begin
            edit_hour = (edit_hour + 5'd1 >= HOURS) ? 5'd0 : edit_hour + 5'd1;
         end
         POS_MINUTE: begin
            edit_minute = (edit_minute + 6'd1 >= MINUTES) ? 6'd0 : edit_minute + 6'd1;
         end
         default: ;
      endcase
   endfunction

   function automatic rsp_type next_status(logic [REQ_W-1:0] word);
      logic       start_down;
      logic       memory_down;
      logic [7:0] total;
      logic [8:0] index_next;
      key_type    fired;
      rsp_type    s;
      start_down = !word[0];
      memory_down = !word[1];
      total = word[9:2];
      fired = KEY_NONE;
      s = '0;
      if (!start_down && !memory_down) begin
         last_key = KEY_NONE;
         fired = pending_key;
         pending_key = KEY_NONE;
      end else if (start_down && memory_down) begin
         debounce_scan(KEY_COMBO);
      end else if (start_down) begin
         debounce_scan(KEY_START);
      end else begin
         debounce_scan(KEY_MEMORY);
      end
      if (fired != KEY_NONE) begin
         case (ctrl_mode)
            MODE_STANDBY: begin
               if (fired == KEY_COMBO) ctrl_mode = MODE_DATESET;
               else if (fired == KEY_START) ctrl_mode = MODE_MEASURE;
               else ctrl_mode = MODE_MEMORY;
            end
            MODE_DATESET: begin
               if (fired == KEY_START) begin
                  if (edit_position >= POS_MINUTE) begin
                     edit_position = POS_MONTH;
                     ctrl_mode = MODE_STANDBY;
                     s.clock_load = 1'b1;
                  end else begin
                     edit_position = edit_position + 3'd1;
                  end
               end else begin
                  step_edited_field();
               end
            end
            MODE_MEASURE: begin
               if (fired != KEY_MEMORY) begin
                  ctrl_mode = MODE_STANDBY;
                  s.measure_stop = 1'b1;
                  s.record_close = 1'b1;
               end
            end
            default: begin
               if (fired != KEY_MEMORY) begin
                  ctrl_mode = MODE_STANDBY;
                  browse_index = '0;
                  s.record_close = 1'b1;
               end else begin
                  index_next = {1'b0, browse_index} + 9'd1;
                  if (index_next >= {1'b0, total}) begin
                     ctrl_mode = MODE_STANDBY;
                     browse_index = '0;
                     s.record_close = 1'b1;
                  end else begin
                     browse_index = index_next[7:0];
                     s.record_refresh = 1'b1;
                  end
               end
            end
         endcase
      end
      s.mode = ctrl_mode;
      s.set_position = edit_position;
      s.month_value = edit_month;
      s.day_value = edit_day;
      s.hour_value = edit_hour;
      s.minute_value = edit_minute;
      s.record_index = browse_index;
      s.key_event = fired;
      return s;
   endfunction

   task automatic report_mismatch(string what);
      mismatches++;
      $display("%0t ns: mismatch, %s", $time, what);
   endtask

   task automatic compare_field(string name, int got, int want);
      if (got != want) report_mismatch($sformatf("%s is %0d, should be %0d", name, got, want));
   endtask

   task automatic check_status(rsp_type got);
      rsp_type want;
      if (status_due.size() == 0) begin
         report_mismatch("result with no request outstanding");
      end else begin
         want = status_due.pop_front();
         compare_field("mode", int'(got.mode), int'(want.mode));
         compare_field("set_position", int'(got.set_position), int'(want.set_position));
         compare_field("month_value", int'(got.month_value), int'(want.month_value));
         compare_field("day_value", int'(got.day_value), int'(want.day_value));
         compare_field("hour_value", int'(got.hour_value), int'(want.hour_value));
         compare_field("minute_value", int'(got.minute_value), int'(want.minute_value));
         compare_field("record_index", int'(got.record_index), int'(want.record_index));
         compare_field("key_event", int'(got.key_event), int'(want.key_event));
         compare_field("clock_load", int'(got.clock_load), int'(want.clock_load));
         compare_field("measure_stop", int'(got.measure_stop), int'(want.measure_stop));
         compare_field("record_close", int'(got.record_close), int'(want.record_close));
         compare_field("record_refresh", int'(got.record_refresh),
                       int'(want.record_refresh));
      end
   endtask

   always @(posedge clock) begin
      req_taken <= req_tvalid && req_tready;
      rsp_taken <= rsp_tvalid && rsp_tready;
      if (!reset) begin
         if (req_tvalid && req_tready) status_due.push_back(next_status(req_tdata));
         if (rsp_tvalid && rsp_tready) check_status(rsp_tdata);
      end
   end

   function automatic int unsigned draw_pause();
      if ($urandom_range(0, 47) == 0) calm = !calm;
      return calm ? 0 : $urandom_range(0, 5);
   endfunction

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (req_gap > 0) begin
            req_tvalid <= 1'b0;
            req_gap--;
         end else if (scan_queue.size() > 0) begin
            req_tdata <= scan_queue.pop_front();
            req_tvalid <= 1'b1;
            req_gap = draw_pause();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b1;
      end else begin
         if (rsp_taken) rsp_stall = draw_pause();
         if (rsp_stall > 0) begin
            rsp_tready <= 1'b0;
            rsp_stall--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic queue_scan(logic start_pin, logic memory_pin, logic [7:0] total);
      scan_queue.push_back({{(REQ_W - 10){1'b0}}, total, memory_pin, start_pin});
      queued_scans++;
   endtask

   task automatic queue_press(key_type k, int unsigned len, logic [7:0] total);
      repeat (len) queue_scan(!(k == KEY_START || k == KEY_COMBO),
                              !(k == KEY_MEMORY || k == KEY_COMBO), total);
   endtask

   function automatic key_type pick_key(int unsigned start_weight);
      int unsigned w;
      w = $urandom_range(0, 99);
      if (w < start_weight) return KEY_START;
      if (w < start_weight + 25) return KEY_COMBO;
      return KEY_MEMORY;
   endfunction

   task automatic queue_random_phase(int unsigned count, int unsigned start_weight);
      int unsigned target;
      int unsigned len;
      int unsigned pick;
      logic [7:0]  browse_total;
      target = queued_scans + count;
      browse_total = 8'($urandom_range(0, 12));
      while (queued_scans < target) begin
         if ($urandom_range(0, 7) == 0)
            browse_total = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                       : 8'($urandom_range(0, 12));
         pick = $urandom_range(0, 99);
         len = hold_cfg + 1 + $urandom_range(0, 2);
         if ($urandom_range(0, 9) == 0) len = $urandom_range(1, hold_cfg + 1);
         else if ($urandom_range(0, 19) == 0) len = $urandom_range(16, 24);
         if (pick < 80) begin
            queue_press(pick_key(start_weight), len, browse_total);
         end else if (pick < 90) begin
            queue_press(pick_key(start_weight), len, browse_total);
            queue_press(pick_key(50), $urandom_range(1, hold_cfg + 3), browse_total);
         end else begin
            repeat ($urandom_range(1, 6))
               queue_scan(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          8'($urandom_range(0, 255)));
         end
         queue_press(KEY_NONE, $urandom_range(1, 3), browse_total);
      end
   endtask

   task automatic wait_drained();
      while (scan_queue.size() != 0 || req_tvalid || status_due.size() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_register(logic idx, logic [6:0] value);
      @(negedge clock);
      csr_index <= idx;
      csr_data <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      if (idx == REG_YEAR) year_cfg = value;
      else hold_cfg = value[3:0];
      @(negedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      queue_press(KEY_NONE, 1, 8'd255);
      queue_press(KEY_START, 5, 8'd255);
      queue_press(KEY_NONE, 1, 8'd255);
      queue_press(KEY_MEMORY, 5, 8'd0);
      queue_press(KEY_NONE, 1, 8'd0);
      queue_press(KEY_COMBO, 5, 8'd255);
      queue_press(KEY_NONE, 1, 8'd255);
      queue_press(KEY_MEMORY, 5, 8'd255);
      queue_press(KEY_START, 2, 8'd255);
      queue_press(KEY_NONE, 1, 8'd255);
      queue_random_phase(280, 30);

      for (int p = 0; p < 5; p++) begin
         wait_drained();
         write_register(REG_YEAR, (p < 4) ? 7'(phase_year[p]) : 7'($urandom_range(0, 99)));
         write_register(REG_HOLD, (p < 4) ? 7'(phase_hold[p]) : 7'($urandom_range(1, 15)));
         queue_random_phase(300, (p < 4) ? phase_start[p] : 25);
      end

      wait_drained();
      repeat (5) @(posedge clock);
      if (mismatches == 0 && status_due.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
